/* src/kpls_pkg.sv */
// Package for the key pool level and status block.
// Holds field widths, reset values, item kinds, status codes and register indexes.
// No dependencies.
package kpls_pkg;

    localparam int LEVEL_W    = 32;
    localparam int KEY_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int WINDOW_DEF = 8;
    localparam int SPAN_START = 5;

    localparam logic [LEVEL_W-1:0] MIN_BITS_RST   = 32'd1000000;
    localparam logic [LEVEL_W-1:0] THRESH_RST     = 32'd2000000;
    localparam logic [LEVEL_W-1:0] MAX_BITS_RST   = 32'd1000000000;
    localparam logic [LEVEL_W-1:0] START_LEVEL_RST = 32'd5000000;

    typedef enum logic [1:0] {
        KIND_NEW     = 2'd0,
        KIND_XFORM   = 2'd1,
        KIND_CONSUME = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_CHARGING = 2'd1,
        ST_WARNING  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_BITS    = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_MAX_BITS    = 2'd2,
        REG_START_LEVEL = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               accepted;
        logic [LEVEL_W-1:0] level;
        status_t            status;
        logic               rising;
    } result_t;

endpackage

/* src/kpls_cell.sv */
// One cell of the level window: holds one past level and compares it with the new one.
// Depends on kpls_pkg for the level width.
module kpls_cell (
    input  logic                         clk,
    input  logic                         shift,
    input  logic [kpls_pkg::LEVEL_W-1:0] level_in,
    input  logic                         active,
    input  logic [kpls_pkg::LEVEL_W-1:0] cmp_level,
    output logic [kpls_pkg::LEVEL_W-1:0] level_out,
    output logic                         not_below
);

    logic [kpls_pkg::LEVEL_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= level_in;
        end
    end

    assign level_out = value_reg;
    assign not_below = !active || (cmp_level >= value_reg);

endmodule

/* src/kpls_window.sv */
// Window of recent levels built as a chain of kpls_cell, newest in cell zero.
// Tracks the fill count and reports whether the new level is not below any kept level.
// Depends on kpls_pkg and kpls_cell.
module kpls_window #(
    parameter int  WINDOW = kpls_pkg::WINDOW_DEF,
    localparam int FILL_W = $clog2(WINDOW + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         record,
    input  logic [FILL_W-1:0]            span,
    input  logic [kpls_pkg::LEVEL_W-1:0] new_level,
    output logic                         rising
);

    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;
    logic [FILL_W-1:0]            kept;
    logic [kpls_pkg::LEVEL_W-1:0] cell_in  [WINDOW];
    logic [kpls_pkg::LEVEL_W-1:0] cell_out [WINDOW];
    logic [WINDOW-1:0]            active;
    logic [WINDOW-1:0]            not_below;

    assign kept = (fill_reg < span) ? fill_reg : span;

    always_comb
    begin
        if (kept == FILL_W'(WINDOW))
        begin
            fill_next = kept;
        end
        else
        begin
            fill_next = kept + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (record)
        begin
            fill_reg <= fill_next;
        end
    end

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_in[i] = new_level;
        end
        else
        begin : g_body
            assign cell_in[i] = cell_out[i-1];
        end

        assign active[i] = FILL_W'(i) < kept;

        kpls_cell u_cell (
            .clk       (clk),
            .shift     (record),
            .level_in  (cell_in[i]),
            .active    (active[i]),
            .cmp_level (new_level),
            .level_out (cell_out[i]),
            .not_below (not_below[i])
        );
    end

    assign rising = &not_below;

endmodule

/* src/key_pool_level_status.sv */
// Top level of the key pool level and status block.
// Holds the pool level, span and status registers and the output buffer.
// Depends on kpls_pkg and kpls_window.
//
//   channel   signals                                    direction
//   input     in_valid, in_ready, kind, key_bits         item in
//   output    out_valid, out_ready, accepted, level,     item out
//             status, rising
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  register write in
//
// One item is taken per cycle while in_ready is high; the result is registered for the output.
// The pool level update, the window compare and the status rule are combinational.
// A second result register catches one item while the output stalls; in_ready drops
// when it is full and while a register write is offered.
// Reset loads the default registers and the start level; the window contents start undefined.
// Configuration writes are taken in every cycle.
module key_pool_level_status #(
    parameter int  WINDOW = kpls_pkg::WINDOW_DEF,
    localparam int FILL_W = $clog2(WINDOW + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     kind,
    input  logic [kpls_pkg::KEY_W-1:0]     key_bits,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           accepted,
    output logic [kpls_pkg::LEVEL_W-1:0]   level,
    output logic [1:0]                     status,
    output logic                           rising,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kpls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kpls_pkg::LEVEL_W-1:0]   cfg_data
);

    localparam logic [FILL_W-1:0] SPAN_RESET =
        FILL_W'((kpls_pkg::SPAN_START < WINDOW) ? kpls_pkg::SPAN_START : WINDOW);
    localparam logic [FILL_W-1:0] SPAN_CAP = FILL_W'(WINDOW - 1);

    logic [kpls_pkg::LEVEL_W-1:0] min_bits_reg;
    logic [kpls_pkg::LEVEL_W-1:0] thresh_reg;
    logic [kpls_pkg::LEVEL_W-1:0] max_bits_reg;
    logic [kpls_pkg::LEVEL_W-1:0] pool_level_reg;
    logic [kpls_pkg::LEVEL_W-1:0] since_reg;
    logic [kpls_pkg::LEVEL_W-1:0] since_next;
    logic [FILL_W-1:0]            span_reg;
    logic [FILL_W-1:0]            span_used;
    kpls_pkg::status_t            prior_status_reg;
    kpls_pkg::status_t            status_next;
    logic                         rising_reg;
    logic                         rising_comb;

    logic                         in_fire;
    logic                         cfg_fire;
    kpls_pkg::kind_t              kind_in;
    logic [kpls_pkg::LEVEL_W:0]   sum;
    logic [kpls_pkg::LEVEL_W-1:0] size_ext;
    logic [kpls_pkg::LEVEL_W-1:0] level_next;
    logic                         acc_comb;
    logic                         record;
    logic                         is_new;
    kpls_pkg::result_t            result;

    logic                         out_valid_reg;
    logic                         skid_valid_reg;
    kpls_pkg::result_t            out_data_reg;
    kpls_pkg::result_t            skid_data_reg;

    assign in_ready  = !skid_valid_reg && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign kind_in   = kpls_pkg::kind_t'(kind);
    assign size_ext  = kpls_pkg::LEVEL_W'(key_bits);
    assign sum       = {1'b0, pool_level_reg} + {1'b0, size_ext};

    always_comb
    begin
        level_next = pool_level_reg;
        acc_comb   = 1'b0;
        record     = 1'b0;
        is_new     = 1'b0;
        since_next = since_reg;
        unique case (kind_in)
            kpls_pkg::KIND_NEW:
            begin
                is_new     = 1'b1;
                record     = 1'b1;
                since_next = kpls_pkg::LEVEL_W'(1);
                if (sum < {1'b0, max_bits_reg})
                begin
                    acc_comb   = 1'b1;
                    level_next = sum[kpls_pkg::LEVEL_W-1:0];
                end
            end
            kpls_pkg::KIND_XFORM:
            begin
                if (sum[kpls_pkg::LEVEL_W])
                begin
                    level_next = '1;
                end
                else
                begin
                    acc_comb   = 1'b1;
                    level_next = sum[kpls_pkg::LEVEL_W-1:0];
                end
            end
            kpls_pkg::KIND_CONSUME:
            begin
                record     = 1'b1;
                since_next = since_reg + 1'b1;
                if (size_ext > pool_level_reg)
                begin
                    level_next = '0;
                end
                else
                begin
                    acc_comb   = 1'b1;
                    level_next = pool_level_reg - size_ext;
                end
            end
            kpls_pkg::KIND_NONE:
            begin
                level_next = pool_level_reg;
            end
            default:
            begin
                level_next = pool_level_reg;
            end
        endcase
    end

    always_comb
    begin
        if (!is_new)
        begin
            span_used = span_reg;
        end
        else if (since_reg > kpls_pkg::LEVEL_W'(WINDOW - 1))
        begin
            span_used = SPAN_CAP;
        end
        else
        begin
            span_used = since_reg[FILL_W-1:0];
        end
    end

    kpls_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .record    (in_fire && record),
        .span      (span_used),
        .new_level (level_next),
        .rising    (rising_comb)
    );

    always_comb
    begin
        if (level_next >= thresh_reg)
        begin
            status_next = kpls_pkg::ST_READY;
        end
        else if (level_next > min_bits_reg &&
                 ((rising_comb && prior_status_reg != kpls_pkg::ST_READY) ||
                  prior_status_reg == kpls_pkg::ST_EMPTY))
        begin
            status_next = kpls_pkg::ST_CHARGING;
        end
        else if (level_next > min_bits_reg && prior_status_reg != kpls_pkg::ST_CHARGING)
        begin
            status_next = kpls_pkg::ST_WARNING;
        end
        else if (level_next <= min_bits_reg)
        begin
            status_next = kpls_pkg::ST_EMPTY;
        end
        else
        begin
            status_next = prior_status_reg;
        end
    end

    always_comb
    begin
        result.accepted = acc_comb;
        result.level    = level_next;
        result.status   = record ? status_next : prior_status_reg;
        result.rising   = record ? rising_comb : rising_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_bits_reg     <= kpls_pkg::MIN_BITS_RST;
            thresh_reg       <= kpls_pkg::THRESH_RST;
            max_bits_reg     <= kpls_pkg::MAX_BITS_RST;
            pool_level_reg   <= kpls_pkg::START_LEVEL_RST;
            since_reg        <= '0;
            span_reg         <= SPAN_RESET;
            prior_status_reg <= kpls_pkg::ST_READY;
            rising_reg       <= 1'b0;
        end
        else if (cfg_fire)
        begin
            unique case (kpls_pkg::cfg_reg_t'(cfg_index))
                kpls_pkg::REG_MIN_BITS:    min_bits_reg   <= cfg_data;
                kpls_pkg::REG_THRESHOLD:   thresh_reg     <= cfg_data;
                kpls_pkg::REG_MAX_BITS:    max_bits_reg   <= cfg_data;
                kpls_pkg::REG_START_LEVEL: pool_level_reg <= cfg_data;
                default:                   min_bits_reg   <= min_bits_reg;
            endcase
        end
        else if (in_fire)
        begin
            pool_level_reg <= level_next;
            since_reg      <= since_next;
            if (is_new)
            begin
                span_reg <= span_used;
            end
            if (record)
            begin
                prior_status_reg <= status_next;
                rising_reg       <= rising_comb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_ready)
            begin
                if (in_fire)
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (in_fire)
            begin
                skid_data_reg <= result;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (in_fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = out_data_reg.accepted;
    assign level     = out_data_reg.level;
    assign status    = out_data_reg.status;
    assign rising    = out_data_reg.rising;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output register is empty");

    a_new_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_fire && is_new && acc_comb) |=> (pool_level_reg < max_bits_reg))
        else $error("accepted new key left the level at or above capacity");

    a_consume_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_fire && kind_in == kpls_pkg::KIND_CONSUME && !acc_comb)
        |=> (pool_level_reg == '0))
        else $error("saturated consume did not clear the level");

    a_level_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_fire && !cfg_fire) |=> $stable(pool_level_reg))
        else $error("pool level changed without an item or a register write");

endmodule

/* tb/sv/kpls_tb_pkg.sv */
// Scoreboard for the key pool level and status block: it tracks the pool level,
// the level window and the status, and checks every result against its own prediction.
// Depends on kpls_pkg.
`timescale 1ns / 100ps
package kpls_tb_pkg;

    import kpls_pkg::*;

    class pool_status_scoreboard;
        logic [LEVEL_W-1:0] min_bits;
        logic [LEVEL_W-1:0] threshold_bits;
        logic [LEVEL_W-1:0] max_bits;
        logic [LEVEL_W-1:0] start_level;
        logic [LEVEL_W-1:0] pool_level;
        logic [LEVEL_W-1:0] level_window [WINDOW_DEF];
        int unsigned        window_fill;
        int unsigned        window_span;
        logic [LEVEL_W-1:0] entry_count;
        logic [LEVEL_W-1:0] last_add_entry;
        status_t            prior_status;
        logic               rising_flag;
        result_t            level_reports_q [$];
        int                 mismatches;

        function new();
            mismatches = 0;
            min_bits = MIN_BITS_RST;
            threshold_bits = THRESH_RST;
            max_bits = MAX_BITS_RST;
            start_level = START_LEVEL_RST;
            pool_level = START_LEVEL_RST;
            foreach (level_window[i])
                level_window[i] = '0;
            window_fill = 0;
            window_span = SPAN_START;
            entry_count = '0;
            last_add_entry = '0;
            prior_status = ST_READY;
            rising_flag = 1'b0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [LEVEL_W-1:0] data);
            case (idx)
                REG_MIN_BITS:    min_bits = data;
                REG_THRESHOLD:   threshold_bits = data;
                REG_MAX_BITS:    max_bits = data;
                REG_START_LEVEL:
                begin
                    start_level = data;
                    pool_level = data;
                end
                default: ;
            endcase
        endfunction

        // Records the level in the window, updates the rising flag and applies the status rule.
        function void record_level();
            int unsigned        kept;
            logic               up;
            logic [LEVEL_W-1:0] lv;
            status_t            st;
            kept = (window_fill < window_span) ? window_fill : window_span;
            up = 1'b1;
            lv = pool_level;
            st = prior_status;
            for (int i = 0; i < kept; i++)
                if (lv < level_window[i])
                    up = 1'b0;
            for (int i = WINDOW_DEF - 1; i > 0; i--)
                level_window[i] = level_window[i-1];
            level_window[0] = lv;
            window_fill = (kept + 1 > WINDOW_DEF) ? WINDOW_DEF : kept + 1;
            rising_flag = up;
            if (lv >= threshold_bits)
                st = ST_READY;
            else if (lv > min_bits &&
                     ((up && prior_status != ST_READY) || prior_status == ST_EMPTY))
                st = ST_CHARGING;
            else if (lv > min_bits && prior_status != ST_CHARGING)
                st = ST_WARNING;
            else if (lv <= min_bits)
                st = ST_EMPTY;
            prior_status = st;
            entry_count = entry_count + 1;
        endfunction

        function void note_item(kind_t k, logic [KEY_W-1:0] bits);
            logic [LEVEL_W:0]   sum;
            logic [LEVEL_W-1:0] span;
            logic               acc;
            result_t            r;
            sum = {1'b0, pool_level} + bits;
            acc = 1'b0;
            case (k)
                KIND_NEW:
                begin
                    span = entry_count - last_add_entry;
                    if (span > WINDOW_DEF - 1)
                        span = WINDOW_DEF - 1;
                    if (sum < {1'b0, max_bits})
                    begin
                        pool_level = sum[LEVEL_W-1:0];
                        acc = 1'b1;
                    end
                    window_span = span;
                    last_add_entry = entry_count;
                    record_level();
                end
                KIND_XFORM:
                begin
                    if (sum[LEVEL_W])
                        pool_level = '1;
                    else
                    begin
                        pool_level = sum[LEVEL_W-1:0];
                        acc = 1'b1;
                    end
                end
                KIND_CONSUME:
                begin
                    if (bits > pool_level)
                        pool_level = '0;
                    else
                    begin
                        pool_level = pool_level - bits;
                        acc = 1'b1;
                    end
                    record_level();
                end
                default: ;
            endcase
            r.accepted = acc;
            r.level = pool_level;
            r.status = prior_status;
            r.rising = rising_flag;
            level_reports_q.insert(level_reports_q.size(), r);
        endfunction

        function void check_result(logic acc, logic [LEVEL_W-1:0] lvl, logic [1:0] st,
                                   logic rise);
            result_t e;
            if (level_reports_q.size() == 0)
            begin
                $error("result with no item pending: level %0d", lvl);
                mismatches++;
                return;
            end
            e = level_reports_q.pop_front();
            if (acc !== e.accepted)
            begin
                $error("accepted: expected %0d, actual %0d", e.accepted, acc);
                mismatches++;
            end
            if (lvl !== e.level)
            begin
                $error("level: expected %0d, actual %0d", e.level, lvl);
                mismatches++;
            end
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                mismatches++;
            end
            if (rise !== e.rising)
            begin
                $error("rising: expected %0d, actual %0d", e.rising, rise);
                mismatches++;
            end
        endfunction

        function int pending();
            return level_reports_q.size();
        endfunction
    endclass

endpackage

/* tb/sv/testbench.sv */
// Top of the key pool level and status testbench: clock, reset, item and register drivers.
// Runs a directed sequence, then random phases under several register settings.
// Depends on kpls_pkg, kpls_tb_pkg and key_pool_level_status.
`timescale 1ns / 100ps
module testbench;

    import kpls_pkg::*;
    import kpls_tb_pkg::*;

    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int RANDOM_PHASES   = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           kind;
    logic [KEY_W-1:0]     key_bits;
    logic                 out_valid;
    logic                 out_ready;
    logic                 accepted;
    logic [LEVEL_W-1:0]   level;
    logic [1:0]           status;
    logic                 rising;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_data;

    bit calm;
    bit hold_req;

    pool_status_scoreboard sb;

    key_pool_level_status u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .key_bits  (key_bits),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .accepted  (accepted),
        .level     (level),
        .status    (status),
        .rising    (rising),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #4000000;
        $display("FAIL key_pool_level_status");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(accepted, level, status, rising);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] pick_bits();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        if (r < 30)
            return KEY_W'($urandom_range(1, 4095));
        return KEY_W'($urandom_range(0, 20'hFFFFF));
    endfunction

    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
                stall = pick_gap();
            else
                stall = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(input kind_t k, input logic [KEY_W-1:0] b);
        int gap;
        gap = calm ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        kind <= k;
        key_bits <= b;
        do @(posedge clk); while (!in_ready);
        sb.note_item(k, b);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [LEVEL_W-1:0] d);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Steers the level back toward the thresholds so that the status keeps changing.
    task automatic send_random();
        kind_t              k;
        int                 r;
        logic [LEVEL_W-1:0] lv;
        r = $urandom_range(0, 99);
        lv = sb.pool_level;
        if (r < 4)
            k = KIND_NONE;
        else if (r < 16)
            k = KIND_XFORM;
        else if ({1'b0, lv} > {1'b0, sb.threshold_bits} + 33'd3000000)
            k = (r < 76) ? KIND_CONSUME : KIND_NEW;
        else if (lv <= sb.min_bits)
            k = (r < 76) ? KIND_NEW : KIND_CONSUME;
        else
            k = (r < 58) ? KIND_NEW : KIND_CONSUME;
        send_item(k, pick_bits());
    endtask

    task automatic random_config(input int sel);
        logic [LEVEL_W-1:0] mn;
        logic [LEVEL_W-1:0] th;
        logic [LEVEL_W-1:0] mx;
        logic [LEVEL_W-1:0] st;
        case (sel)
            7:
            begin
                th = $urandom_range(0, 2000000);
                mn = th + $urandom_range(1, 2000000);
                mx = '1;
                st = $urandom_range(0, 5000000);
            end
            8:
            begin
                mn = '0;
                th = '1;
                mx = '1;
                st = 32'hFFFF_FFFF - $urandom_range(0, 4000000);
            end
            9:
            begin
                mn = '1;
                th = '0;
                mx = $urandom_range(0, 8000000);
                st = $urandom_range(0, 3000000);
            end
            default:
            begin
                mn = $urandom_range(0, 3000000);
                th = mn + $urandom_range(0, 3000000);
                mx = th + $urandom_range(1000000, 6000000);
                st = $urandom_range(0, th + 2000000);
            end
        endcase
        cfg_write(REG_MIN_BITS, mn);
        cfg_write(REG_THRESHOLD, th);
        cfg_write(REG_MAX_BITS, mx);
        cfg_write(REG_START_LEVEL, st);
    endtask

    initial
    begin
        int sel;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_NEW;
        key_bits = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_BITS;
        cfg_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(KIND_NEW, '0);
        send_item(KIND_NEW, '1);
        send_item(KIND_XFORM, '0);
        send_item(KIND_XFORM, '1);
        send_item(KIND_NONE, '1);
        send_item(KIND_CONSUME, '0);
        repeat (8) send_item(KIND_CONSUME, '1);
        repeat (3) send_item(KIND_NEW, '1);
        send_item(KIND_NONE, '0);

        cfg_write(REG_MAX_BITS, '0);
        send_item(KIND_NEW, 20'd5);

        cfg_write(REG_MIN_BITS, 32'd3000000);
        cfg_write(REG_THRESHOLD, 32'd1000000);
        cfg_write(REG_START_LEVEL, 32'd2000000);
        send_item(KIND_NEW, '0);
        send_item(KIND_CONSUME, '1);

        cfg_write(REG_MAX_BITS, '1);
        cfg_write(REG_START_LEVEL, 32'hFFFF_FFF0);
        send_item(KIND_XFORM, 20'h20);
        send_item(KIND_NEW, '0);

        cfg_write(REG_START_LEVEL, '0);
        send_item(KIND_CONSUME, 20'd1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            sel = (p == 2) ? 8 : (p == 5) ? 7 : (p == 7) ? 9 : $urandom_range(0, 6);
            random_config(sel);
            calm = (p == 3 || p == 6);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 1 && i == 60)
                    hold_req = 1'b1;
                if (p == 4 && i == 100)
                    drain();
                send_random();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS key_pool_level_status");
        else
            $display("FAIL key_pool_level_status");
        $finish;
    end

endmodule

/* files.f */
src/kpls_pkg.sv
src/kpls_cell.sv
src/kpls_window.sv
src/key_pool_level_status.sv
tb/sv/kpls_tb_pkg.sv
tb/sv/testbench.sv
